// ===== hw/rtl/skyline_rect_packer_core_assert.svh =====
// Assertion macros for the skyline packer core.
// Included by the top level; no other dependencies.
`ifndef SKYLINE_RECT_PACKER_CORE_ASSERT_SVH
`define SKYLINE_RECT_PACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skyline packer check failed");
`define SRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skyline packer check failed");
`else
`define SRP_ASSERT_NOW(lbl, ante, cons)
`define SRP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/srp_pkg.sv =====
// Shared types and constants for the skyline packer core.
// No dependencies.
package srp_pkg;
  localparam int SRP_MAX_SEGMENTS = 64;
  localparam int SRP_COORD_BITS   = 16;
  localparam logic [7:0] SRP_THR_RESET = 8'd8;
  localparam logic [2:0] SRP_REG_THR   = 3'd0;

  localparam logic OP_PLACE  = 1'b0;
  localparam logic OP_EXTEND = 1'b1;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_EXTENDED = 2'd2,
    ST_FULL     = 2'd3
  } srp_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EXT, S_CW, S_ORD, S_OCHK, S_IRD, S_ICHK, S_DEC, S_RF, S_RL,
    S_WF, S_WL, S_ERD, S_EWR, S_SRD, S_SWR, S_SWN, S_DONE
  } srp_state_t;
endpackage

// ===== hw/rtl/srp_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module srp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/skyline_rect_packer_core.sv =====
// Skyline rectangle packer, top level.
// Depends on srp_pkg, srp_ram and skyline_rect_packer_core_assert.svh.
//
// Usage:
// - Input stream: tuser = opcode (0 place, 1 extend), tdata = size_x, size_y.
//   One request is taken only while the sequencer is idle.
// - Output stream: one result per request; tuser = status, tdata = the
//   rectangle corners (zero unless placed).
// - APB port: register 0 (byte address 0) is improve_threshold, reset 8.
// - Sequence: extend writes the new segment, then moves its result to the
//   output register. A place request walks the segment table through the
//   single RAM read port (a run walk may revisit segments), then reads the
//   chosen run's ends, then moves table entries one at a time on a split
//   or erase.
// - The segment table lives in one RAM word per segment {length, top, x}.
// - Reset: empty table, canvas height 0; RAM contents are not cleared,
//   only entries below seg_count are ever read.
// - Stall: a finished result waits in the sequencer until the output
//   register is free; a new request is taken as soon as the result moves
//   into the output register.
module skyline_rect_packer_core
  import srp_pkg::*;
#(
  parameter int MAX_SEGMENTS = SRP_MAX_SEGMENTS,
  parameter int COORD_BITS   = SRP_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] size_x, [31:16] size_y
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // rect_left, rect_top, rect_right, rect_bottom
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int CB   = COORD_BITS;
  localparam int SW   = ((CB > 16) ? CB : 16) + 1;  // wide enough for any sum
  localparam int WW   = 3 * CB;
  localparam logic [SW-1:0] CMAX = SW'((64'd1 << CB) - 64'd1);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_SEGMENTS);

  function automatic logic [15:0] to16(input logic [CB-1:0] v);
    logic [SW-1:0] t;
    t = SW'(v);
    return t[15:0];
  endfunction

  // config
  logic [7:0] thr;
  assign pready = 1'b1;
  assign prdata = (paddr == SRP_REG_THR) ? {24'd0, thr} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= SRP_THR_RESET;
    end else if (psel && penable && pwrite && paddr == SRP_REG_THR) begin
      thr <= pwdata[7:0];
    end
  end

  // segment RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [CB-1:0] rd_x, rd_top, rd_len;
  assign rd_x   = rdata[CB-1:0];
  assign rd_top = rdata[2*CB-1:CB];
  assign rd_len = rdata[3*CB-1:2*CB];

  srp_ram #(.WIDTH(WW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // sequencer state
  srp_state_t state, state_next;
  logic [CNTW-1:0] seg_count, seg_count_next;
  logic [CB-1:0]   canvas_height, canvas_height_next;
  logic [15:0]     w, h;
  logic [CNTW-1:0] i, i_next, j, j_next, cfirst, cfirst_next;
  logic [CNTW-1:0] first, first_next, last, last_next, k, k_next, d, d_next;
  logic [CB-1:0]   cwidth, cwidth_next, avail, avail_next, maxtop, maxtop_next;
  logic [CB-1:0]   best, best_next;
  logic            found, found_next, case_a, case_a_next;
  logic [CB-1:0]   ef_x, ef_len, el_top, el_len, el_x;
  logic [CB-1:0]   ef_x_next, ef_len_next, el_top_next, el_len_next, el_x_next;
  logic [CB-1:0]   right, right_next, bot, bot_next;
  srp_status_t     res_st, res_st_next;
  logic [63:0]     res_rect, res_rect_next;
  logic            out_load;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seg_count     <= '0;
      canvas_height <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      seg_count     <= seg_count_next;
      canvas_height <= canvas_height_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      w  <= s_tdata[15:0];
      h  <= s_tdata[31:16];
    end
    if (out_load) begin
      m_tuser <= res_st;
      m_tdata <= res_rect;
    end
    i <= i_next;  j <= j_next;  cfirst <= cfirst_next;
    first <= first_next;  last <= last_next;  k <= k_next;  d <= d_next;
    cwidth <= cwidth_next;  avail <= avail_next;  maxtop <= maxtop_next;
    best <= best_next;  found <= found_next;  case_a <= case_a_next;
    ef_x <= ef_x_next;  ef_len <= ef_len_next;
    el_x <= el_x_next;  el_top <= el_top_next;  el_len <= el_len_next;
    right <= right_next;  bot <= bot_next;
    res_st <= res_st_next;  res_rect <= res_rect_next;
  end

  always_comb begin
    logic [SW-1:0] x0, rem, dxw, chs, av, lhs;
    logic [CB-1:0] mt;
    logic [CNTW-1:0] ii;
    logic          brk;
    state_next = state;
    seg_count_next = seg_count;  canvas_height_next = canvas_height;
    i_next = i;  j_next = j;  cfirst_next = cfirst;  first_next = first;
    last_next = last;  k_next = k;  d_next = d;  cwidth_next = cwidth;
    avail_next = avail;  maxtop_next = maxtop;  best_next = best;
    found_next = found;  case_a_next = case_a;
    ef_x_next = ef_x;  ef_len_next = ef_len;  el_x_next = el_x;
    el_top_next = el_top;  el_len_next = el_len;
    right_next = right;  bot_next = bot;
    res_st_next = res_st;  res_rect_next = res_rect;
    we = 1'b0;  waddr = '0;  wdata = '0;  raddr = '0;  out_load = 1'b0;
    x0 = '0;  rem = '0;  dxw = '0;  chs = '0;  av = '0;  lhs = '0;
    mt = maxtop;  ii = i;  brk = 1'b0;
    unique case (state)
      S_IDLE: begin
        raddr = AW'(seg_count - 1'b1);
        res_rect_next = '0;
        if (s_tvalid) begin
          if (s_tuser == OP_EXTEND) begin
            if (seg_count == CNT_MAX) begin
              res_st_next = ST_FULL;
              state_next = S_DONE;
            end else begin
              state_next = S_EXT;
            end
          end else if (seg_count == '0) begin
            res_st_next = ST_NOFIT;
            state_next = S_DONE;
          end else begin
            state_next = S_CW;
          end
        end
      end
      S_EXT: begin
        x0 = (seg_count == '0) ? '0 : SW'(rd_x) + SW'(rd_len);
        if (x0 > CMAX) x0 = CMAX;
        rem = CMAX - x0;
        dxw = (SW'(w) > rem) ? rem : SW'(w);
        we = 1'b1;
        waddr = AW'(seg_count);
        wdata = {CB'(dxw), {CB{1'b0}}, CB'(x0)};
        seg_count_next = seg_count + 1'b1;
        chs = SW'(canvas_height) + SW'(h);
        canvas_height_next = (chs > CMAX) ? CB'(CMAX) : CB'(chs);
        res_st_next = ST_EXTENDED;
        state_next = S_DONE;
      end
      S_CW: begin
        cwidth_next = CB'(SW'(rd_x) + SW'(rd_len));
        i_next = '0;
        found_next = 1'b0;
        best_next = '0;
        state_next = S_ORD;
      end
      S_ORD: begin
        raddr = AW'(i);
        state_next = (i >= seg_count) ? S_DEC : S_OCHK;
      end
      S_OCHK: begin
        raddr = AW'(i);
        if (SW'(rd_x) + SW'(w) > SW'(cwidth)) begin
          state_next = S_DEC;
        end else if ((found && rd_top >= best) ||
                     (SW'(rd_top) + SW'(h) > SW'(canvas_height))) begin
          i_next = i + 1'b1;
          state_next = S_ORD;
        end else begin
          cfirst_next = i;  j_next = i;
          avail_next = '0;  maxtop_next = '0;
          state_next = S_ICHK;
        end
      end
      S_IRD: begin
        raddr = AW'(j);
        state_next = S_ICHK;
      end
      S_ICHK: begin
        if (maxtop <= rd_top) begin
          mt = rd_top;
          ii = j;
          if (SW'(rd_top) + SW'(h) > SW'(canvas_height)) brk = 1'b1;
        end
        if (brk) begin
          i_next = j + 1'b1;
          state_next = S_ORD;
        end else begin
          av = SW'(avail) + SW'(rd_len);
          lhs = SW'(mt) + SW'(thr);
          if (av >= SW'(w)) begin
            if (!found || SW'(best) > lhs) begin
              found_next = 1'b1;  best_next = mt;
              first_next = cfirst;  last_next = j;
            end
            i_next = ii + 1'b1;
            state_next = S_ORD;
          end else if (j + 1'b1 >= seg_count) begin
            i_next = ii + 1'b1;
            state_next = S_ORD;
          end else begin
            j_next = j + 1'b1;
            maxtop_next = mt;
            avail_next = CB'(av);
            i_next = ii;
            state_next = S_IRD;
          end
        end
      end
      S_DEC: begin
        raddr = AW'(first);
        if (!found) begin
          res_st_next = ST_NOFIT;
          state_next = S_DONE;
        end else begin
          state_next = S_RF;
        end
      end
      S_RF: begin
        raddr = AW'(last);
        ef_x_next = rd_x;  ef_len_next = rd_len;
        right_next = CB'(SW'(rd_x) + SW'(w));
        bot_next = CB'(SW'(best) + SW'(h));
        state_next = S_RL;
      end
      S_RL: begin
        el_x_next = rd_x;  el_top_next = rd_top;  el_len_next = rd_len;
        case_a_next = (SW'(rd_x) + SW'(rd_len) == SW'(right));
        res_st_next = ST_PLACED;
        res_rect_next = {to16(bot), to16(right), to16(best), to16(ef_x)};
        if (SW'(rd_x) + SW'(rd_len) == SW'(right) || first != last) begin
          state_next = S_WF;
        end else if (seg_count == CNT_MAX) begin
          res_st_next = ST_FULL;
          res_rect_next = '0;
          state_next = S_DONE;
        end else begin
          k_next = seg_count;
          state_next = S_SRD;
        end
      end
      S_WF: begin
        we = 1'b1;
        waddr = AW'(first);
        wdata = {((case_a && first == last) ? ef_len : CB'(SW'(w))), bot, ef_x};
        if (case_a) begin
          k_next = last + 1'b1;
          d_next = last - first;
          state_next = S_ERD;
        end else if (first != last) begin
          state_next = S_WL;
        end else begin
          seg_count_next = seg_count + 1'b1;
          state_next = S_DONE;
        end
      end
      S_WL: begin
        we = 1'b1;
        waddr = AW'(last);
        wdata = {CB'(el_len - (right - el_x)), el_top, right};
        k_next = last;
        d_next = last - first - 1'b1;
        state_next = S_ERD;
      end
      S_ERD: begin
        raddr = AW'(k);
        if (k >= seg_count) begin
          seg_count_next = seg_count - d;
          state_next = S_DONE;
        end else begin
          state_next = S_EWR;
        end
      end
      S_EWR: begin
        we = 1'b1;
        waddr = AW'(k - d);
        wdata = rdata;
        k_next = k + 1'b1;
        state_next = S_ERD;
      end
      S_SRD: begin
        raddr = AW'(k - 1'b1);
        state_next = (k <= first + 1'b1) ? S_SWN : S_SWR;
      end
      S_SWR: begin
        we = 1'b1;
        waddr = AW'(k);
        wdata = rdata;
        k_next = k - 1'b1;
        state_next = S_SRD;
      end
      S_SWN: begin
        we = 1'b1;
        waddr = AW'(first + 1'b1);
        wdata = {CB'(SW'(ef_len) - SW'(w)), el_top, right};
        state_next = S_WF;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`include "skyline_rect_packer_core_assert.svh"
  `SRP_ASSERT_NOW(a_count_bound, 1'b1, seg_count <= CNT_MAX)
  `SRP_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
  `SRP_ASSERT_NEXT(a_idle_count_stable, state == S_IDLE, $stable(seg_count))
endmodule

// ===== tb/srp_checker.sv =====
// Checker for the skyline packer core: watches the request, result and APB channels.
// Keeps its own skyline table and compares every result. Depends on srp_pkg.
module srp_checker
  import srp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CMAX = (64'd1 << SRP_COORD_BITS) - 1;

  typedef struct packed {
    srp_status_t st;
    logic [15:0] left, top, right, bottom;
  } rect_res_t;

  rect_res_t       rect_q[$];
  longint unsigned col_x[SRP_MAX_SEGMENTS];
  longint unsigned col_top[SRP_MAX_SEGMENTS];
  longint unsigned col_len[SRP_MAX_SEGMENTS];
  int              col_cnt;
  longint unsigned canvas_h;
  longint unsigned thresh;

  function automatic rect_res_t mk_res(srp_status_t st, longint unsigned l, longint unsigned t,
                                       longint unsigned r, longint unsigned b);
    rect_res_t v;
    v.st = st;
    v.left = l[15:0];
    v.top = t[15:0];
    v.right = r[15:0];
    v.bottom = b[15:0];
    return v;
  endfunction

  task automatic drop_cols(int lo, int hi);
    int d;
    d = hi - lo;
    for (int k = hi; k < col_cnt; k++) begin
      col_x[k-d] = col_x[k];
      col_top[k-d] = col_top[k];
      col_len[k-d] = col_len[k];
    end
    col_cnt -= d;
  endtask

  task automatic grow_canvas(longint unsigned dx, longint unsigned dy, output rect_res_t r);
    longint unsigned x;
    x = 0;
    if (col_cnt >= SRP_MAX_SEGMENTS) begin
      r = mk_res(ST_FULL, 0, 0, 0, 0);
      return;
    end
    if (col_cnt > 0) x = col_x[col_cnt-1] + col_len[col_cnt-1];
    if (x > CMAX) x = CMAX;
    if (dx > CMAX - x) dx = CMAX - x;
    col_x[col_cnt] = x;
    col_top[col_cnt] = 0;
    col_len[col_cnt] = dx;
    col_cnt++;
    canvas_h += dy;
    if (canvas_h > CMAX) canvas_h = CMAX;
    r = mk_res(ST_EXTENDED, 0, 0, 0, 0);
  endtask

  task automatic fit_rect(longint unsigned w, longint unsigned h, output rect_res_t r);
    bit found;
    longint unsigned best, cw, left, top, right, bottom, avail, maxtop;
    int first, last, cfirst;
    found = 0;
    best = 0;
    first = 0;
    last = 0;
    if (col_cnt == 0) begin
      r = mk_res(ST_NOFIT, 0, 0, 0, 0);
      return;
    end
    cw = col_x[col_cnt-1] + col_len[col_cnt-1];
    for (int i = 0; i < col_cnt; i++) begin
      avail = 0;
      maxtop = 0;
      cfirst = i;
      if (col_x[i] + w > cw) break;
      if ((found && col_top[i] >= best) || col_top[i] + h > canvas_h) continue;
      // the inner walk moves the outer index to the highest segment seen
      for (int j = cfirst; j < col_cnt; j++) begin
        if (maxtop <= col_top[j]) begin
          maxtop = col_top[j];
          i = j;
          if (maxtop + h > canvas_h) break;
        end
        avail += col_len[j];
        if (avail >= w) begin
          if (!found || best > maxtop + thresh) begin
            found = 1;
            best = maxtop;
            first = cfirst;
            last = j;
          end
          break;
        end
      end
    end
    if (!found) begin
      r = mk_res(ST_NOFIT, 0, 0, 0, 0);
      return;
    end
    left = col_x[first];
    top = best;
    right = left + w;
    bottom = top + h;
    if (col_x[last] + col_len[last] == right) begin
      col_top[first] = bottom;
      if (first != last) begin
        col_len[first] = w;
        drop_cols(first + 1, last + 1);
      end
    end else if (first != last) begin
      col_top[first] = bottom;
      col_len[first] = w;
      col_len[last] -= right - col_x[last];
      col_x[last] = right;
      drop_cols(first + 1, last);
    end else begin
      if (col_cnt >= SRP_MAX_SEGMENTS) begin
        r = mk_res(ST_FULL, 0, 0, 0, 0);
        return;
      end
      for (int k = col_cnt; k > first + 1; k--) begin
        col_x[k] = col_x[k-1];
        col_top[k] = col_top[k-1];
        col_len[k] = col_len[k-1];
      end
      col_x[first+1] = right;
      col_top[first+1] = col_top[first];
      col_len[first+1] = col_len[first] - w;
      col_cnt++;
      col_top[first] = bottom;
      col_len[first] = w;
    end
    r = mk_res(ST_PLACED, left, top, right, bottom);
  endtask

  always @(posedge clk) begin
    rect_res_t want, got;
    if (rst) begin
      col_cnt = 0;
      canvas_h = 0;
      thresh = 64'(SRP_THR_RESET);
      rect_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(SRP_REG_THR * 4))
        thresh = 64'(pwdata[7:0]);
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_EXTEND) begin
          grow_canvas(64'(s_tdata[15:0]), 64'(s_tdata[31:16]), want);
        end else begin
          fit_rect(64'(s_tdata[15:0]), 64'(s_tdata[31:16]), want);
        end
        rect_q = {rect_q, want};
      end
      if (m_tvalid && m_tready) begin
        got = mk_res(srp_status_t'(m_tuser), m_tdata[15:0], m_tdata[31:16],
                     m_tdata[47:32], m_tdata[63:48]);
        if (rect_q.size() == 0) begin
          $error("unexpected result, status %0d", m_tuser);
          errors++;
        end else begin
          want = rect_q.pop_front();
          if (got.st != want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            errors++;
          end
          if (got.left != want.left) begin
            $error("rect_left: expected %0d, got %0d", want.left, got.left);
            errors++;
          end
          if (got.top != want.top) begin
            $error("rect_top: expected %0d, got %0d", want.top, got.top);
            errors++;
          end
          if (got.right != want.right) begin
            $error("rect_right: expected %0d, got %0d", want.right, got.right);
            errors++;
          end
          if (got.bottom != want.bottom) begin
            $error("rect_bottom: expected %0d, got %0d", want.bottom, got.bottom);
            errors++;
          end
        end
      end
    end
    pending = rect_q.size();
  end
endmodule

// ===== tb/tb.sv =====
// Top of the skyline packer testbench: clock, reset, requests, APB writes, verdict.
// Depends on srp_pkg, skyline_rect_packer_core and srp_checker.
module tb;
  import srp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // idle cycles with no handshake before the run is declared hung
  localparam int WATCHDOG = 20000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = OP_PLACE;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int idle_cycles = 0;
  bit hold_req = 0;   // asks the receiver for one long hold-off
  bit no_gaps = 0;    // sender runs back to back while set

  always #5 clk = ~clk;

  skyline_rect_packer_core dut (.*);

  srp_checker chk (.*);

  // watchdog: any accepted request, result or register write clears it
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side: random stalls, runs without stalls, one long hold-off on request
  initial begin
    int gap;
    bit burst;
    burst = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      if ($urandom_range(0, 19) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_tready = 0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one request; valid stays high into the next one when the gap is zero
  task automatic send_req(logic op, logic [15:0] w, logic [15:0] h);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tuser = op;
    s_tdata = {h, w};
    s_tvalid = 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // APB write: setup then access, block idle
  task automatic write_thresh(logic [7:0] v);
    drain();
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = 3'(SRP_REG_THR * 4);
    pwdata = {24'd0, v};
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  // mostly small shapes so the table fills, sometimes full-range values
  task automatic rand_req;
    logic op;
    logic [15:0] w, h;
    op = ($urandom_range(0, 99) < 30) ? OP_EXTEND : OP_PLACE;
    if ($urandom_range(0, 19) == 0) begin
      w = 16'($urandom);
      h = 16'($urandom);
    end else if (op == OP_EXTEND) begin
      w = 16'($urandom_range(0, 300));
      h = 16'($urandom_range(0, 400));
    end else begin
      w = 16'($urandom_range(0, 350));
      h = 16'($urandom_range(0, 150));
    end
    send_req(op, w, h);
  endtask

  initial begin
    logic [7:0] thr_set[10];
    thr_set = '{8'd0, 8'd255, 8'd8, 8'd1, 8'd0, 8'd40, 8'd255, 8'd3, 8'd0, 8'd100};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty table, zero sizes, exact fit, saturation, splits
    send_req(OP_PLACE, 16'd10, 16'd10);       // empty table
    send_req(OP_EXTEND, 16'd0, 16'd0);        // zero-length segment
    send_req(OP_PLACE, 16'd0, 16'd0);         // zero rectangle
    send_req(OP_EXTEND, 16'd100, 16'd50);
    send_req(OP_PLACE, 16'd100, 16'd50);      // exact width and height
    send_req(OP_PLACE, 16'hffff, 16'hffff);   // no fit
    send_req(OP_EXTEND, 16'hffff, 16'hffff);  // saturates width and height
    send_req(OP_EXTEND, 16'd5, 16'd5);        // appended with length 0
    send_req(OP_PLACE, 16'd30, 16'd10);       // split
    send_req(OP_PLACE, 16'd40, 16'd12);
    send_req(OP_PLACE, 16'd200, 16'd7);       // spans several segments
    send_req(OP_PLACE, 16'd0, 16'd100);
    send_req(OP_PLACE, 16'd65000, 16'd1);
    write_thresh(8'd255);                     // first fit wins
    send_req(OP_PLACE, 16'd20, 16'd3);
    send_req(OP_PLACE, 16'd20, 16'd3);
    write_thresh(8'd0);
    send_req(OP_PLACE, 16'd20, 16'd3);
    send_req(OP_PLACE, 16'd1, 16'd65535);
    send_req(OP_EXTEND, 16'h8000, 16'h8000);

    // random phases, threshold changed between them
    for (int ph = 0; ph < 10; ph++) begin
      write_thresh(thr_set[ph]);
      for (int n = 0; n < 130; n++) begin
        if (ph == 3 && n == 10) hold_req = 1;           // fill up and stall the input
        if (ph == 5 && n == 60) drain();                // sender waits for every result
        no_gaps = (ph == 3 && n < 60) || (ph == 7 && n >= 50 && n < 90);
        rand_req();
      end
    end
    no_gaps = 0;
    write_thresh(8'($urandom_range(0, 255)));
    repeat (20) rand_req();

    drain();
    repeat (500) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/srp_pkg.sv
hw/rtl/srp_ram.sv
hw/rtl/skyline_rect_packer_core.sv
tb/srp_checker.sv
tb/tb.sv
